/* rtl/core/iida_pkg.sv */
// ----------------------------------------------------------------------------
// iida_pkg
// Shared constants, codes and control types for the indexed insert/delete
// array.
// ----------------------------------------------------------------------------
package iida_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int ELEM_W  = 32;
  localparam int RWORD_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_WRITE
  } op_e;

  typedef struct packed {
    logic              load;
    op_e               op;
    logic [EXT_W-1:0]  idx;
    logic [STAT_W-1:0] status;
    logic              hit;
  } dp_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
  } dp_sts_t;

endpackage

/* rtl/core/indexed_insert_delete_array.sv */
// Latency: the result of a transfer is valid in the cycle after it is accepted.
// Throughput: one command per cycle; every shift is done at once by the
// register-array cells, and a new command is taken while the output is free.
// Reset: asynchronous, active low; clears the entry count and the handshake
// state. Entry contents are not cleared and are read only after a write.
// ----------------------------------------------------------------------------
// indexed_insert_delete_array
// Ordered word array with append, insert, read, remove and replace by index.
// ----------------------------------------------------------------------------
module indexed_insert_delete_array (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [iida_pkg::CMD_W-1:0]     command_i,
  input  logic [iida_pkg::POS_W-1:0]     position_i,
  input  logic [iida_pkg::ELEM_W-1:0]    element_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [iida_pkg::RWORD_W-1:0]   read_word_o,
  output logic                           found_o,
  output logic [iida_pkg::STAT_W-1:0]    status_o,
  output logic [iida_pkg::COUNT_W-1:0]   count_o
);

  iida_pkg::dp_cmd_t cmd;
  iida_pkg::dp_sts_t sts;

  iida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  iida_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .element_i   (element_i),
    .sts_o       (sts),
    .read_word_o (read_word_o),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iida_pkg::EXT_W'(sts.used) <= iida_pkg::EXT_W'(iida_pkg::CAPACITY)))
    else $error("entry count above capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (status_o == iida_pkg::STAT_OK))
    else $error("hit reported with error status");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && (command_i == iida_pkg::CMD_APPEND) &&
     (iida_pkg::EXT_W'(sts.used) < iida_pkg::EXT_W'(iida_pkg::CAPACITY)))
    |=> (sts.used == $past(sts.used) + 1'b1))
    else $error("append did not grow the array");

  a_stall_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

/* rtl/core/iida_ctrl.sv */
// ----------------------------------------------------------------------------
// iida_ctrl
// Handshake state machine and command decode: checks index and fill level
// and issues one datapath command per accepted transfer.
// ----------------------------------------------------------------------------
module iida_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [iida_pkg::CMD_W-1:0]   command_i,
  input  logic [iida_pkg::POS_W-1:0]   position_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  iida_pkg::dp_sts_t            sts_i,
  output iida_pkg::dp_cmd_t            cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;
  logic full;
  logic [iida_pkg::EXT_W-1:0] pos_ext, used_ext;

  assign in_stall_o  = (state_q == S_HOLD) && out_stall_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = S_HOLD;
    end else if ((state_q == S_HOLD) && !out_stall_i) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign pos_ext  = iida_pkg::EXT_W'(position_i);
  assign used_ext = iida_pkg::EXT_W'(sts_i.used);
  assign full     = (used_ext == iida_pkg::EXT_W'(iida_pkg::CAPACITY));

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    cmd_o.op     = iida_pkg::OP_NONE;
    cmd_o.idx    = pos_ext;
    cmd_o.status = iida_pkg::STAT_OK;
    cmd_o.hit    = 1'b0;
    unique case (command_i)
      iida_pkg::CMD_APPEND: begin
        if (full) begin
          cmd_o.status = iida_pkg::STAT_FULL;
        end else begin
          cmd_o.op  = iida_pkg::OP_INSERT;
          cmd_o.idx = used_ext;
        end
      end
      iida_pkg::CMD_INSERT: begin
        if (pos_ext > used_ext) begin
          cmd_o.status = iida_pkg::STAT_BAD_INDEX;
        end else if (full) begin
          cmd_o.status = iida_pkg::STAT_FULL;
        end else begin
          cmd_o.op = iida_pkg::OP_INSERT;
        end
      end
      iida_pkg::CMD_READ: begin
        if (pos_ext >= used_ext) begin
          cmd_o.status = iida_pkg::STAT_BAD_INDEX;
        end else begin
          cmd_o.hit = 1'b1;
        end
      end
      iida_pkg::CMD_REMOVE: begin
        if (pos_ext >= used_ext) begin
          cmd_o.status = iida_pkg::STAT_BAD_INDEX;
        end else begin
          cmd_o.op = iida_pkg::OP_REMOVE;
        end
      end
      iida_pkg::CMD_REPLACE: begin
        if (pos_ext >= used_ext) begin
          cmd_o.status = iida_pkg::STAT_BAD_INDEX;
        end else begin
          cmd_o.op = iida_pkg::OP_WRITE;
        end
      end
      default: begin
        cmd_o.op = iida_pkg::OP_NONE;
      end
    endcase
  end

endmodule

/* rtl/core/iida_dp.sv */
// ----------------------------------------------------------------------------
// iida_dp
// Entry cells with parallel shift up / shift down, entry count and the
// result registers.
// ----------------------------------------------------------------------------
module iida_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  iida_pkg::dp_cmd_t              cmd_i,
  input  logic [iida_pkg::ELEM_W-1:0]    element_i,
  output iida_pkg::dp_sts_t              sts_o,
  output logic [iida_pkg::RWORD_W-1:0]   read_word_o,
  output logic                           found_o,
  output logic [iida_pkg::STAT_W-1:0]    status_o,
  output logic [iida_pkg::COUNT_W-1:0]   count_o
);

  logic [iida_pkg::DATA_WIDTH-1:0] entries_q [iida_pkg::CAPACITY];
  logic [iida_pkg::DATA_WIDTH-1:0] word;
  logic [iida_pkg::CNT_W-1:0]      used_q, used_d;
  logic [iida_pkg::EXT_W-1:0]      used_ext;
  logic [iida_pkg::DATA_WIDTH-1:0] rd_q, rd_d;
  logic                            found_q;
  logic [iida_pkg::STAT_W-1:0]     status_q;

  assign word     = iida_pkg::DATA_WIDTH'(element_i);
  assign used_ext = iida_pkg::EXT_W'(used_q);

  for (genvar i = 0; i < iida_pkg::CAPACITY; i++) begin : g_cell
    localparam logic [iida_pkg::EXT_W-1:0] CellIdx  = iida_pkg::EXT_W'(i);
    localparam logic [iida_pkg::EXT_W-1:0] CellNext = iida_pkg::EXT_W'(i + 1);
    logic [iida_pkg::DATA_WIDTH-1:0] up_w, dn_w;

    if (i > 0) begin : g_up
      assign up_w = entries_q[i-1];
    end else begin : g_up0
      assign up_w = word;
    end
    if (i < iida_pkg::CAPACITY - 1) begin : g_dn
      assign dn_w = entries_q[i+1];
    end else begin : g_dnl
      assign dn_w = entries_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        unique case (cmd_i.op)
          iida_pkg::OP_INSERT: begin
            if (CellIdx == cmd_i.idx) begin
              entries_q[i] <= word;
            end else if ((CellIdx > cmd_i.idx) && (CellIdx <= used_ext)) begin
              entries_q[i] <= up_w;
            end
          end
          iida_pkg::OP_REMOVE: begin
            if ((CellIdx >= cmd_i.idx) && (CellNext < used_ext)) begin
              entries_q[i] <= dn_w;
            end
          end
          iida_pkg::OP_WRITE: begin
            if (CellIdx == cmd_i.idx) begin
              entries_q[i] <= word;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    used_d = used_q;
    if (cmd_i.load) begin
      unique case (cmd_i.op)
        iida_pkg::OP_INSERT: used_d = used_q + 1'b1;
        iida_pkg::OP_REMOVE: used_d = used_q - 1'b1;
        default:             used_d = used_q;
      endcase
    end
  end

  assign rd_d = cmd_i.hit ? entries_q[cmd_i.idx[iida_pkg::IDX_W-1:0]]
                          : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_q     <= rd_d;
      found_q  <= cmd_i.hit;
      status_q <= cmd_i.status;
    end
  end

  assign sts_o.used  = used_q;
  assign read_word_o = iida_pkg::RWORD_W'(rd_q);
  assign found_o     = found_q;
  assign status_o    = status_q;
  assign count_o     = used_ext[iida_pkg::COUNT_W-1:0];

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for indexed_insert_delete_array. Directed command sequences
// cover the empty array, shifting by insert and remove, and the full array.
// A random command mix follows, alternating growing and shrinking phases.
// A shadow array predicts every result. A checker compares each output
// transfer field by field. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [iida_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd5;
  localparam logic [iida_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd6;
  localparam logic [iida_pkg::CMD_W-1:0] CMD_RSVD_C = 3'd7;

  localparam int IDLE_PCT = 13;

  typedef struct {
    logic [iida_pkg::RWORD_W-1:0] word;
    logic                         hit;
    logic [iida_pkg::STAT_W-1:0]  status;
    logic [iida_pkg::COUNT_W-1:0] count;
  } result_t;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic [iida_pkg::CMD_W-1:0]    command_i   = '0;
  logic [iida_pkg::POS_W-1:0]    position_i  = '0;
  logic [iida_pkg::ELEM_W-1:0]   element_i   = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [iida_pkg::RWORD_W-1:0]  read_word_o;
  logic                          found_o;
  logic [iida_pkg::STAT_W-1:0]   status_o;
  logic [iida_pkg::COUNT_W-1:0]  count_o;

  logic [iida_pkg::DATA_WIDTH-1:0] shadow_mem [iida_pkg::CAPACITY];
  int                              shadow_used = 0;
  result_t                         expected_q [$];
  result_t                         exp_r;
  int                              error_count = 0;
  int                              idle_pct    = IDLE_PCT;
  int                              stall_pct   = IDLE_PCT;

  indexed_insert_delete_array u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .element_i   (element_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_word_o (read_word_o),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  function automatic result_t predict_array_result(
      logic [iida_pkg::CMD_W-1:0]  cmd,
      logic [iida_pkg::POS_W-1:0]  pos,
      logic [iida_pkg::ELEM_W-1:0] elem);
    result_t                         r;
    logic [iida_pkg::DATA_WIDTH-1:0] word;
    int                              p;
    int                              i;
    r.word   = '0;
    r.hit    = 1'b0;
    r.status = iida_pkg::STAT_OK;
    word     = elem[iida_pkg::DATA_WIDTH-1:0];
    p        = pos;
    case (cmd)
      iida_pkg::CMD_APPEND: begin
        if (shadow_used >= iida_pkg::CAPACITY) begin
          r.status = iida_pkg::STAT_FULL;
        end else begin
          shadow_mem[shadow_used] = word;
          shadow_used++;
        end
      end
      iida_pkg::CMD_INSERT: begin
        if (p > shadow_used) begin
          r.status = iida_pkg::STAT_BAD_INDEX;
        end else if (shadow_used >= iida_pkg::CAPACITY) begin
          r.status = iida_pkg::STAT_FULL;
        end else begin
          for (i = shadow_used; i > p; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[p] = word;
          shadow_used++;
        end
      end
      iida_pkg::CMD_READ: begin
        if (p >= shadow_used) begin
          r.status = iida_pkg::STAT_BAD_INDEX;
        end else begin
          r.word = iida_pkg::RWORD_W'(shadow_mem[p]);
          r.hit  = 1'b1;
        end
      end
      iida_pkg::CMD_REMOVE: begin
        if (p >= shadow_used) begin
          r.status = iida_pkg::STAT_BAD_INDEX;
        end else begin
          for (i = p; i + 1 < shadow_used; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_used--;
        end
      end
      iida_pkg::CMD_REPLACE: begin
        if (p >= shadow_used) begin
          r.status = iida_pkg::STAT_BAD_INDEX;
        end else begin
          shadow_mem[p] = word;
        end
      end
      default: ;
    endcase
    r.count = shadow_used[iida_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // random output back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result transfer", {27'd0, count_o}, '0);
      end else begin
        exp_r = expected_q.pop_front();
        check_field("read_word", read_word_o, exp_r.word);
        check_field("found", {31'd0, found_o}, {31'd0, exp_r.hit});
        check_field("status", {30'd0, status_o}, {30'd0, exp_r.status});
        check_field("count", {27'd0, count_o}, {27'd0, exp_r.count});
      end
    end
  end

  // one command transfer; the expectation is queued at the accepting edge
  task automatic send_item(logic [iida_pkg::CMD_W-1:0] cmd,
                           logic [iida_pkg::POS_W-1:0] pos,
                           logic [iida_pkg::ELEM_W-1:0] elem);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    element_i  <= elem;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(predict_array_result(cmd, pos, elem));
  endtask

  task automatic test_empty_array();
    send_item(iida_pkg::CMD_READ, 5'd0, 32'h0);
    send_item(iida_pkg::CMD_REMOVE, 5'd0, 32'h0);
    send_item(iida_pkg::CMD_REPLACE, 5'd0, 32'hFFFF_FFFF);
    send_item(iida_pkg::CMD_INSERT, 5'd1, 32'h1234_5678);
    send_item(CMD_RSVD_A, 5'd31, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_B, 5'd0, 32'h0);
    send_item(CMD_RSVD_C, 5'd16, 32'hA5A5_A5A5);
  endtask

  task automatic test_shift_ops();
    send_item(iida_pkg::CMD_INSERT, 5'd0, 32'hFFFF_FFFF);
    send_item(iida_pkg::CMD_APPEND, 5'd31, 32'h0000_0000);
    send_item(iida_pkg::CMD_INSERT, 5'd2, 32'h8000_0001);
    send_item(iida_pkg::CMD_INSERT, 5'd1, 32'h5555_AAAA);
    send_item(iida_pkg::CMD_READ, 5'd31, 32'h0);
    send_item(iida_pkg::CMD_READ, 5'd3, 32'h0);
    send_item(iida_pkg::CMD_REPLACE, 5'd0, 32'h0F0F_F0F0);
    send_item(iida_pkg::CMD_REMOVE, 5'd0, 32'h0);
    send_item(iida_pkg::CMD_REMOVE, 5'd2, 32'h0);
    send_item(iida_pkg::CMD_READ, 5'd0, 32'h0);
  endtask

  task automatic test_full_array();
    int i;
    for (i = 0; shadow_used < iida_pkg::CAPACITY; i++) begin
      if (i % 2 == 0) send_item(iida_pkg::CMD_INSERT, 5'd0, $urandom());
      else send_item(iida_pkg::CMD_APPEND, 5'd0, $urandom());
    end
    send_item(iida_pkg::CMD_APPEND, 5'd0, 32'hDEAD_BEEF);
    send_item(iida_pkg::CMD_INSERT, 5'd16, 32'hDEAD_BEEF);
    send_item(iida_pkg::CMD_INSERT, 5'd17, 32'hDEAD_BEEF);
    send_item(iida_pkg::CMD_READ, 5'd15, 32'h0);
    send_item(iida_pkg::CMD_READ, 5'd16, 32'h0);
  endtask

  task automatic test_random_mix(int n_items);
    int                          i;
    int                          roll;
    logic                        grow;
    logic [iida_pkg::CMD_W-1:0]  cmd;
    logic [iida_pkg::POS_W-1:0]  pos;
    logic [iida_pkg::ELEM_W-1:0] elem;
    for (i = 0; i < n_items; i++) begin
      if (i >= 400 && i < 600) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
      end
      grow = ((i / 64) % 2) == 0;
      roll = $urandom_range(99);
      if (grow) begin
        if (roll < 35) cmd = iida_pkg::CMD_APPEND;
        else if (roll < 60) cmd = iida_pkg::CMD_INSERT;
        else if (roll < 75) cmd = iida_pkg::CMD_READ;
        else if (roll < 85) cmd = iida_pkg::CMD_REPLACE;
        else if (roll < 95) cmd = iida_pkg::CMD_REMOVE;
        else cmd = CMD_RSVD_A + iida_pkg::CMD_W'($urandom_range(2));
      end else begin
        if (roll < 10) cmd = iida_pkg::CMD_APPEND;
        else if (roll < 20) cmd = iida_pkg::CMD_INSERT;
        else if (roll < 40) cmd = iida_pkg::CMD_READ;
        else if (roll < 50) cmd = iida_pkg::CMD_REPLACE;
        else if (roll < 95) cmd = iida_pkg::CMD_REMOVE;
        else cmd = CMD_RSVD_A + iida_pkg::CMD_W'($urandom_range(2));
      end
      roll = $urandom_range(99);
      if (roll < 70 && shadow_used > 0) begin
        pos = iida_pkg::POS_W'($urandom_range(shadow_used - 1));
      end else if (roll < 85) begin
        pos = iida_pkg::POS_W'($urandom_range(shadow_used));
      end else begin
        pos = iida_pkg::POS_W'($urandom_range(31));
      end
      roll = $urandom_range(99);
      if (roll < 5) elem = '0;
      else if (roll < 10) elem = '1;
      else elem = $urandom();
      send_item(cmd, pos, elem);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_array();
    test_shift_ops();
    test_full_array();
    test_random_mix(1000);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/iida_pkg.sv
rtl/core/iida_ctrl.sv
rtl/core/iida_dp.sv
rtl/core/indexed_insert_delete_array.sv
bench/tb_top.sv
